/* sv/three_segment_cubic_coefficients_top_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the three-segment cubic coefficient block
// Implication checks, same-cycle and next-cycle, reset-qualified.
// ---------------------------------------------------------------------------
`ifndef THREE_SEGMENT_CUBIC_COEFFICIENTS_TOP_ASSERT_SVH
`define THREE_SEGMENT_CUBIC_COEFFICIENTS_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsc: same-cycle pipeline check failed");

// antecedent implies consequent in the next cycle
`define TSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsc: next-cycle pipeline check failed");

`endif

/* sv/tsc_pkg.sv */
// ---------------------------------------------------------------------------
// tsc_pkg
// Types, widths and constants of the three-segment cubic coefficient block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsc_pkg;

    localparam int DW   = 32;   // Q16.16 data
    localparam int TDW  = 31;   // duration
    localparam int QS   = 16;   // fraction bits
    localparam int TW   = 72;   // matrix term / row sum width
    localparam int NCOL = 6;
    localparam int NROW = 9;
    localparam int KW   = 10;

    localparam int SCALE_STAGES = 7;
    localparam int MIX_STAGES   = 3;
    localparam int FIN_STAGES   = 5;
    localparam int NUM_STAGES   = SCALE_STAGES + MIX_STAGES + FIN_STAGES;
    localparam int SEG0_DELAY   = MIX_STAGES + FIN_STAGES;

    // divide by 36: round, drop two bits, then multiply by ceil(2^39 / 9)
    localparam int NOSAT_W     = 37;
    localparam int DIV_A_W     = 35;
    localparam int A_SPLIT     = 17;
    localparam int RECIP_W     = 36;
    localparam int RECIP_SHIFT = 39;
    localparam logic [RECIP_W-1:0] RECIP9 = 36'd61083979321;
    localparam logic [NOSAT_W:0]   DENOM_HALF = 38'd18;

    // row-sum magnitudes at and above which the result clamps
    localparam logic [TW-1:0] SAT_POS_MAG = 72'd77309411310;
    localparam logic [TW-1:0] SAT_NEG_MAG = 72'd77309411346;

    typedef logic signed [DW-1:0] t_data;
    typedef logic [TDW-1:0]       t_dur;
    typedef logic signed [TW-1:0] t_term;
    typedef logic signed [KW-1:0] t_kcoef;

    typedef struct packed {
        t_data c2;
        t_data c1;
        t_data c0;
    } t_seg0;

    localparam t_data DATA_MAX = 32'sh7FFFFFFF;
    localparam t_data DATA_MIN = 32'sh80000000;

    // 36x the rational mixing matrix
    // rows: seg0_c3, seg1_c3..seg1_c0, seg2_c3..seg2_c0
    // cols: start_pos, T*sv, T^2*sa, end_pos, T*ev, T^2*ea
    localparam t_kcoef KMAT [NROW][NCOL] = '{
        '{-10'sd162, -10'sd108, -10'sd33,  10'sd162, -10'sd54,   10'sd6},
        '{ 10'sd324,  10'sd162,  10'sd21, -10'sd324,  10'sd162, -10'sd21},
        '{-10'sd486, -10'sd270, -10'sd36,  10'sd486, -10'sd216,  10'sd27},
        '{ 10'sd162,  10'sd126,  10'sd18, -10'sd162,  10'sd72,  -10'sd9},
        '{ 10'sd18,  -10'sd10,  -10'sd2,   10'sd18,  -10'sd8,    10'sd1},
        '{-10'sd162, -10'sd54,  -10'sd6,   10'sd162, -10'sd108,  10'sd33},
        '{ 10'sd486,  10'sd162,  10'sd18, -10'sd486,  10'sd324, -10'sd81},
        '{-10'sd486, -10'sd162, -10'sd18,  10'sd486, -10'sd288,  10'sd63},
        '{ 10'sd162,  10'sd54,   10'sd6,  -10'sd126,  10'sd72,  -10'sd15}
    };

endpackage

/* sv/tsc_scale.sv */
// ---------------------------------------------------------------------------
// tsc_scale
// Seven-stage front end: scales the velocities by T and the accelerations
// by T^2 with rounding, and forms the first piece's low coefficients.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsc_scale (
    input  logic                                i_clk,
    input  logic [tsc_pkg::SCALE_STAGES-1:0]    i_en,
    input  tsc_pkg::t_data                      i_start_pos,
    input  tsc_pkg::t_data                      i_start_vel,
    input  tsc_pkg::t_data                      i_start_acc,
    input  tsc_pkg::t_data                      i_end_pos,
    input  tsc_pkg::t_data                      i_end_vel,
    input  tsc_pkg::t_data                      i_end_acc,
    input  tsc_pkg::t_dur                       i_duration,
    output tsc_pkg::t_term                      o_q [tsc_pkg::NCOL],
    output tsc_pkg::t_seg0                      o_seg0
);
    import tsc_pkg::*;

    localparam int PW   = 2 * TDW;          // T*T
    localparam int PVW  = TDW + DW;         // T*|v|
    localparam int T2W  = PW - QS;          // T^2 in Q16.16
    localparam int SVW  = PVW - QS;         // |T*v|
    localparam int HW   = T2W / 2;          // T^2 split point
    localparam int PPW  = (T2W - HW) + DW;  // partial products
    localparam int PAW  = T2W + DW;         // T^2*|a|
    localparam int SAW  = PAW - QS;         // |T^2*a|
    localparam int C2W  = PAW - QS - 1;     // |T^2*a/2|
    localparam logic [C2W-1:0] LIM_NEG = C2W'(1) << (DW - 1);
    localparam logic [C2W-1:0] LIM_POS = LIM_NEG - C2W'(1);

    function automatic logic [DW-1:0] mag(input t_data x);
        logic [DW-1:0] u;
        u = x;
        return x[DW-1] ? (~u + 1'b1) : u;
    endfunction

    // stage 0
    t_dur            r0_t;
    t_data           r0_sp, r0_ep;
    logic [DW-1:0]   r0_svm, r0_evm, r0_sam, r0_eam;
    logic            r0_svn, r0_evn, r0_san, r0_ean;
    // stage 1
    logic [PW-1:0]   r1_tt;
    logic [PVW-1:0]  r1_pvs, r1_pve;
    t_data           r1_sp, r1_ep;
    logic [DW-1:0]   r1_sam, r1_eam;
    logic            r1_svn, r1_evn, r1_san, r1_ean;
    // stage 2
    logic [T2W-1:0]  r2_t2;
    logic [SVW-1:0]  r2_svm, r2_evm;
    t_data           r2_sp, r2_ep;
    logic [DW-1:0]   r2_sam, r2_eam;
    logic            r2_svn, r2_evn, r2_san, r2_ean;
    // stage 3
    logic [PPW-1:0]  r3_sah, r3_sal, r3_eah, r3_eal;
    logic signed [SVW:0] r3_sv, r3_ev;
    t_data           r3_sp, r3_ep;
    logic            r3_san, r3_ean;
    // stage 4
    logic [PAW-1:0]  r4_spa, r4_epa;
    logic signed [SVW:0] r4_sv, r4_ev;
    t_data           r4_sp, r4_ep, r4_c1;
    logic            r4_san, r4_ean;
    // stage 5
    logic [SAW-1:0]  r5_sam, r5_eam;
    logic [C2W-1:0]  r5_c2m;
    logic signed [SVW:0] r5_sv, r5_ev;
    t_data           r5_sp, r5_ep, r5_c1;
    logic            r5_san, r5_ean;
    // stage 6
    logic signed [SAW:0] r6_sa, r6_ea;
    logic signed [SVW:0] r6_sv, r6_ev;
    t_data           r6_sp, r6_ep, r6_c1, r6_c2;

    t_data           w_c1, w_c2;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_t   <= i_duration;
            r0_sp  <= i_start_pos;
            r0_ep  <= i_end_pos;
            r0_svm <= mag(i_start_vel);
            r0_evm <= mag(i_end_vel);
            r0_sam <= mag(i_start_acc);
            r0_eam <= mag(i_end_acc);
            r0_svn <= i_start_vel[DW-1];
            r0_evn <= i_end_vel[DW-1];
            r0_san <= i_start_acc[DW-1];
            r0_ean <= i_end_acc[DW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_tt  <= PW'(r0_t) * PW'(r0_t);
            r1_pvs <= PVW'(r0_t) * PVW'(r0_svm);
            r1_pve <= PVW'(r0_t) * PVW'(r0_evm);
            r1_sp  <= r0_sp;
            r1_ep  <= r0_ep;
            r1_sam <= r0_sam;
            r1_eam <= r0_eam;
            r1_svn <= r0_svn;
            r1_evn <= r0_evn;
            r1_san <= r0_san;
            r1_ean <= r0_ean;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r2_t2  <= T2W'((r1_tt + (PW'(1) << (QS - 1))) >> QS);
            r2_svm <= SVW'((r1_pvs + (PVW'(1) << (QS - 1))) >> QS);
            r2_evm <= SVW'((r1_pve + (PVW'(1) << (QS - 1))) >> QS);
            r2_sp  <= r1_sp;
            r2_ep  <= r1_ep;
            r2_sam <= r1_sam;
            r2_eam <= r1_eam;
            r2_svn <= r1_svn;
            r2_evn <= r1_evn;
            r2_san <= r1_san;
            r2_ean <= r1_ean;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r3_sah <= PPW'(r2_t2[T2W-1:HW]) * PPW'(r2_sam);
            r3_sal <= PPW'(r2_t2[HW-1:0]) * PPW'(r2_sam);
            r3_eah <= PPW'(r2_t2[T2W-1:HW]) * PPW'(r2_eam);
            r3_eal <= PPW'(r2_t2[HW-1:0]) * PPW'(r2_eam);
            r3_sv  <= r2_svn ? -$signed({1'b0, r2_svm}) : $signed({1'b0, r2_svm});
            r3_ev  <= r2_evn ? -$signed({1'b0, r2_evm}) : $signed({1'b0, r2_evm});
            r3_sp  <= r2_sp;
            r3_ep  <= r2_ep;
            r3_san <= r2_san;
            r3_ean <= r2_ean;
        end
    end

    always_comb begin
        if (r3_sv > (SVW + 1)'(DATA_MAX)) begin
            w_c1 = DATA_MAX;
        end else if (r3_sv < (SVW + 1)'(DATA_MIN)) begin
            w_c1 = DATA_MIN;
        end else begin
            w_c1 = t_data'(r3_sv[DW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r4_spa <= (PAW'(r3_sah) << HW) + PAW'(r3_sal);
            r4_epa <= (PAW'(r3_eah) << HW) + PAW'(r3_eal);
            r4_sv  <= r3_sv;
            r4_ev  <= r3_ev;
            r4_sp  <= r3_sp;
            r4_ep  <= r3_ep;
            r4_c1  <= w_c1;
            r4_san <= r3_san;
            r4_ean <= r3_ean;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r5_sam <= SAW'((r4_spa + (PAW'(1) << (QS - 1))) >> QS);
            r5_eam <= SAW'((r4_epa + (PAW'(1) << (QS - 1))) >> QS);
            r5_c2m <= C2W'((r4_spa + (PAW'(1) << QS)) >> (QS + 1));
            r5_sv  <= r4_sv;
            r5_ev  <= r4_ev;
            r5_sp  <= r4_sp;
            r5_ep  <= r4_ep;
            r5_c1  <= r4_c1;
            r5_san <= r4_san;
            r5_ean <= r4_ean;
        end
    end

    always_comb begin
        if (r5_san) begin
            w_c2 = (r5_c2m > LIM_NEG) ? DATA_MIN : t_data'(-r5_c2m[DW-1:0]);
        end else begin
            w_c2 = (r5_c2m > LIM_POS) ? DATA_MAX : t_data'(r5_c2m[DW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r6_sa <= r5_san ? -$signed({1'b0, r5_sam}) : $signed({1'b0, r5_sam});
            r6_ea <= r5_ean ? -$signed({1'b0, r5_eam}) : $signed({1'b0, r5_eam});
            r6_sv <= r5_sv;
            r6_ev <= r5_ev;
            r6_sp <= r5_sp;
            r6_ep <= r5_ep;
            r6_c1 <= r5_c1;
            r6_c2 <= w_c2;
        end
    end

    assign o_q[0] = TW'(r6_sp);
    assign o_q[1] = TW'(r6_sv);
    assign o_q[2] = TW'(r6_sa);
    assign o_q[3] = TW'(r6_ep);
    assign o_q[4] = TW'(r6_ev);
    assign o_q[5] = TW'(r6_ea);

    assign o_seg0.c2 = r6_c2;
    assign o_seg0.c1 = r6_c1;
    assign o_seg0.c0 = r6_sp;

endmodule

/* sv/tsc_mix.sv */
// ---------------------------------------------------------------------------
// tsc_mix
// Three-stage constant matrix: term products, pair sums, row sums.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsc_mix (
    input  logic                            i_clk,
    input  logic [tsc_pkg::MIX_STAGES-1:0]  i_en,
    input  tsc_pkg::t_term                  i_q [tsc_pkg::NCOL],
    output tsc_pkg::t_term                  o_s [tsc_pkg::NROW]
);
    import tsc_pkg::*;

    localparam int NHALF = NCOL / 2;

    t_term r_p [NROW][NCOL];
    t_term r_h [NROW][NHALF];
    t_term r_s [NROW];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int r = 0; r < NROW; r++) begin
                for (int c = 0; c < NCOL; c++) begin
                    r_p[r][c] <= i_q[c] * TW'(KMAT[r][c]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int r = 0; r < NROW; r++) begin
                for (int j = 0; j < NHALF; j++) begin
                    r_h[r][j] <= r_p[r][2*j] + r_p[r][2*j+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            for (int r = 0; r < NROW; r++) begin
                r_s[r] <= r_h[r][0] + r_h[r][1] + r_h[r][2];
            end
        end
    end

    assign o_s = r_s;

endmodule

/* sv/tsc_finish.sv */
// ---------------------------------------------------------------------------
// tsc_finish
// Five-stage row finish: rounded divide by 36 and clamp to 32 bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsc_finish (
    input  logic                            i_clk,
    input  logic [tsc_pkg::FIN_STAGES-1:0]  i_en,
    input  tsc_pkg::t_term                  i_s,
    output tsc_pkg::t_data                  o_c
);
    import tsc_pkg::*;

    localparam int PHW  = (DIV_A_W - A_SPLIT) + RECIP_W;
    localparam int PLW  = A_SPLIT + RECIP_W;
    localparam int SUMW = DIV_A_W + RECIP_W;

    logic                 r1_neg;
    logic [TW-1:0]        r1_mag;
    logic                 r2_neg, r2_sat;
    logic [DIV_A_W-1:0]   r2_a;
    logic                 r3_neg, r3_sat;
    logic [PHW-1:0]       r3_ph;
    logic [PLW-1:0]       r3_pl;
    logic                 r4_neg, r4_sat;
    logic [DW-1:0]        r4_q;
    t_data                r5_c;

    logic [SUMW-1:0]      w_sum;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_neg <= i_s[TW-1];
            r1_mag <= i_s[TW-1] ? -i_s : i_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_neg <= r1_neg;
            r2_sat <= r1_mag >= (r1_neg ? SAT_NEG_MAG : SAT_POS_MAG);
            r2_a   <= DIV_A_W'(({1'b0, r1_mag[NOSAT_W-1:0]} + DENOM_HALF) >> 2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_neg <= r2_neg;
            r3_sat <= r2_sat;
            r3_ph  <= PHW'(r2_a[DIV_A_W-1:A_SPLIT]) * PHW'(RECIP9);
            r3_pl  <= PLW'(r2_a[A_SPLIT-1:0]) * PLW'(RECIP9);
        end
    end

    assign w_sum = (SUMW'(r3_ph) << A_SPLIT) + SUMW'(r3_pl);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_neg <= r3_neg;
            r4_sat <= r3_sat;
            r4_q   <= DW'(w_sum >> RECIP_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            if (r4_sat) begin
                r5_c <= r4_neg ? DATA_MIN : DATA_MAX;
            end else begin
                r5_c <= r4_neg ? t_data'(-r4_q) : t_data'(r4_q);
            end
        end
    end

    assign o_c = r5_c;

endmodule

/* sv/three_segment_cubic_coefficients_top.sv */
// ---------------------------------------------------------------------------
// three_segment_cubic_coefficients_top
// Twelve coefficients of a three-piece cubic trajectory in normalized time.
// Input channel (i_valid / o_ready) carries start state, end state and
// duration T, all Q16.16. Output channel (o_valid / i_ready) carries the
// twelve saturated Q16.16 coefficients, highest power first per piece.
// Pipeline: 7 scaling stages (T and T^2 products, split
// multipliers), 3 matrix stages, 5 divide-by-36 and clamp stages.
// Throughput is one transfer per cycle with no stall.
// Each stage holds a valid bit; a stage loads whenever i_ready is high
// or it or any later stage is empty, so bubbles are squeezed out on a stall.
// o_ready drops only when all 15 stages hold items and the result waits.
// Reset clears every valid bit; the data registers are not reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "three_segment_cubic_coefficients_top_assert.svh"

module three_segment_cubic_coefficients_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tsc_pkg::t_data  i_start_pos,
    input  tsc_pkg::t_data  i_start_vel,
    input  tsc_pkg::t_data  i_start_acc,
    input  tsc_pkg::t_data  i_end_pos,
    input  tsc_pkg::t_data  i_end_vel,
    input  tsc_pkg::t_data  i_end_acc,
    input  tsc_pkg::t_dur   i_duration,
    output logic            o_valid,
    input  logic            i_ready,
    output tsc_pkg::t_data  o_seg0_c3,
    output tsc_pkg::t_data  o_seg0_c2,
    output tsc_pkg::t_data  o_seg0_c1,
    output tsc_pkg::t_data  o_seg0_c0,
    output tsc_pkg::t_data  o_seg1_c3,
    output tsc_pkg::t_data  o_seg1_c2,
    output tsc_pkg::t_data  o_seg1_c1,
    output tsc_pkg::t_data  o_seg1_c0,
    output tsc_pkg::t_data  o_seg2_c3,
    output tsc_pkg::t_data  o_seg2_c2,
    output tsc_pkg::t_data  o_seg2_c1,
    output tsc_pkg::t_data  o_seg2_c0
);
    import tsc_pkg::*;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] w_en;

    t_term w_q [NCOL];
    t_term w_s [NROW];
    t_data w_c [NROW];
    t_seg0 w_seg0;
    t_seg0 r_seg0 [SEG0_DELAY];

    // a stage advances when i_ready is high or any stage from it to the output is empty
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
        assign w_en[k] = i_ready | ~(&r_vld[NUM_STAGES-1:k]);
    end

    always_comb begin
        n_vld[0] = w_en[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    tsc_scale u_scale (
        .i_clk       (i_clk),
        .i_en        (w_en[SCALE_STAGES-1:0]),
        .i_start_pos (i_start_pos),
        .i_start_vel (i_start_vel),
        .i_start_acc (i_start_acc),
        .i_end_pos   (i_end_pos),
        .i_end_vel   (i_end_vel),
        .i_end_acc   (i_end_acc),
        .i_duration  (i_duration),
        .o_q         (w_q),
        .o_seg0      (w_seg0)
    );

    tsc_mix u_mix (
        .i_clk (i_clk),
        .i_en  (w_en[SCALE_STAGES+MIX_STAGES-1:SCALE_STAGES]),
        .i_q   (w_q),
        .o_s   (w_s)
    );

    for (genvar r = 0; r < NROW; r++) begin : g_row
        tsc_finish u_finish (
            .i_clk (i_clk),
            .i_en  (w_en[NUM_STAGES-1:NUM_STAGES-FIN_STAGES]),
            .i_s   (w_s[r]),
            .o_c   (w_c[r])
        );
    end

    // first piece's low coefficients ride alongside the matrix and finish stages
    always_ff @(posedge i_clk) begin
        if (w_en[SCALE_STAGES]) begin
            r_seg0[0] <= w_seg0;
        end
        for (int j = 1; j < SEG0_DELAY; j++) begin
            if (w_en[SCALE_STAGES+j]) begin
                r_seg0[j] <= r_seg0[j-1];
            end
        end
    end

    assign o_ready   = w_en[0];
    assign o_valid   = r_vld[NUM_STAGES-1];

    assign o_seg0_c3 = w_c[0];
    assign o_seg0_c2 = r_seg0[SEG0_DELAY-1].c2;
    assign o_seg0_c1 = r_seg0[SEG0_DELAY-1].c1;
    assign o_seg0_c0 = r_seg0[SEG0_DELAY-1].c0;
    assign o_seg1_c3 = w_c[1];
    assign o_seg1_c2 = w_c[2];
    assign o_seg1_c1 = w_c[3];
    assign o_seg1_c0 = w_c[4];
    assign o_seg2_c3 = w_c[5];
    assign o_seg2_c2 = w_c[6];
    assign o_seg2_c1 = w_c[7];
    assign o_seg2_c0 = w_c[8];

    `TSC_ASSERT_SAME(a_empty_out_ready, i_clk, i_rst_n, !o_valid, o_ready)
    `TSC_ASSERT_NEXT(a_transfer_enters, i_clk, i_rst_n, i_valid && o_ready, r_vld[0])
    `TSC_ASSERT_SAME(a_full_blocks_in, i_clk, i_rst_n, (&r_vld) && !i_ready, !o_ready)

endmodule
